@@ design/chte_pkg.sv @@
// Shared types and codes for the chained hash table engine.
`timescale 1ns / 1ps
`default_nettype none

package chte_pkg;

	localparam int KEY_W  = 64;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_SEARCH = 2'd1,
		FN_REMOVE = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_MISS = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_EVAL,
		ST_ADD_WR,
		ST_PROMOTE,
		ST_WALK,
		ST_RELEASE,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] payload;
	} chte_req_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] payload;
	} chte_rsp_t;

endpackage

`default_nettype wire

@@ design/chte_bucket_mod.sv @@
// Bucket index: key mod TABLE_SIZE, a byte per cycle; low bits if pow2.
`timescale 1ns / 1ps
`default_nettype none

module chte_bucket_mod
	import chte_pkg::*;
#(
	parameter int TABLE_SIZE = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [KEY_W-1:0]              key,
	output logic                               done,
	output logic [$clog2(TABLE_SIZE)-1:0]      bucket
);

	localparam int BW      = $clog2(TABLE_SIZE);
	localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
	localparam int DIGIT   = 8;
	localparam int STEPS   = IS_POW2 ? 0 : KEY_W / DIGIT;
	localparam int CW      = $clog2(KEY_W / DIGIT + 1);

	logic [CW-1:0] cnt_q;
	logic [BW-1:0] rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	generate
		if (IS_POW2) begin : g_mask
			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= key[BW-1:0];
				end
			end
		end else begin : g_reduce
			localparam int RW = BW + 1;
			logic [KEY_W-1:0] sh_q;
			logic [RW-1:0]    r;

			// fold one key byte into the remainder, one compare-subtract per bit
			always_comb begin
				r = RW'(rem_q);
				for (int i = 0; i < DIGIT; i++) begin
					r = {r[RW-2:0], sh_q[KEY_W-1-i]};
					if (r >= RW'(TABLE_SIZE)) begin
						r = r - RW'(TABLE_SIZE);
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sh_q  <= key;
					rem_q <= '0;
				end else if (cnt_q != '0) begin
					sh_q  <= sh_q << DIGIT;
					rem_q <= r[BW-1:0];
				end
			end
		end
	endgenerate

	assign done   = (cnt_q == '0);
	assign bucket = rem_q;

endmodule

`default_nettype wire

@@ design/chte_table_ctrl.sv @@
// Sequencer and table memories: bucket array, overflow pool and free list.
`timescale 1ns / 1ps
`default_nettype none

module chte_table_ctrl
	import chte_pkg::*;
#(
	parameter int TABLE_SIZE    = 256,
	parameter int SPILL_SIZE    = 64,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire chte_req_t req,
	input  wire logic      req_valid,
	output logic           req_ready,
	output chte_rsp_t      rsp,
	output logic           rsp_valid,
	input  wire logic      rsp_ready
);

	localparam int BW    = $clog2(TABLE_SIZE);
	localparam int SIW   = (SPILL_SIZE > 1) ? $clog2(SPILL_SIZE) : 1;
	localparam int LW    = $clog2(SPILL_SIZE + 1);
	localparam int SW    = (PAYLOAD_WIDTH < DATA_W) ? PAYLOAD_WIDTH : DATA_W;
	localparam int BMW   = 1 + LW + KEY_W + SW;
	localparam int SDW   = KEY_W + SW;
	localparam int CLR_N = (TABLE_SIZE > SPILL_SIZE) ? TABLE_SIZE : SPILL_SIZE;
	localparam int CLR_W = $clog2(CLR_N);
	localparam logic [LW-1:0] LINK_NULL = LW'(SPILL_SIZE);

	function automatic logic link_ok(input logic [LW-1:0] l);
		return l < LINK_NULL;
	endfunction

	state_t state_q, state_d;

	logic [CLR_W-1:0] clr_q;
	func_t            func_q;
	logic [KEY_W-1:0] key_q;
	logic [SW-1:0]    pay_q;
	logic [BW-1:0]    bkt_q;
	logic [LW-1:0]    free_head_q;
	logic [LW-1:0]    cur_q;
	logic [LW-1:0]    prev_q;
	logic [LW-1:0]    steps_q;
	status_t          res_status_q;
	logic [SW-1:0]    res_pay_q;

	// memories
	logic [BMW-1:0] bucket_mem [TABLE_SIZE];
	logic [SDW-1:0] spill_mem  [SPILL_SIZE];
	logic [LW-1:0]  next_mem   [SPILL_SIZE];
	logic [BMW-1:0] brd_q;
	logic [SDW-1:0] srd_q;
	logic [LW-1:0]  nrd_q;

	logic           bm_we, bm_re;
	logic [BW-1:0]  bm_wa, bm_ra;
	logic [BMW-1:0] bm_wd;
	logic           sd_we, sp_re;
	logic [SIW-1:0] sd_wa, sp_ra;
	logic [SDW-1:0] sd_wd;
	logic           nx_we;
	logic [SIW-1:0] nx_wa;
	logic [LW-1:0]  nx_wd;

	// hash unit
	logic          hash_start, hash_done;
	logic [BW-1:0] hash_bkt;

	// control strobes
	logic          fh_we;
	logic [LW-1:0] fh_d;
	logic          walk_load, walk_adv;
	logic          res_set;
	status_t       res_status_d;
	logic [SW-1:0] res_pay_d;
	logic [KEY_W-1:0] cmp_a;
	logic          key_eq;

	// fields of the registered reads
	logic             b_used;
	logic [LW-1:0]    b_head;
	logic [KEY_W-1:0] b_key;
	logic [SW-1:0]    b_pay;
	logic [KEY_W-1:0] s_key;
	logic [SW-1:0]    s_pay;

	assign b_used = brd_q[BMW-1];
	assign b_head = brd_q[BMW-2 -: LW];
	assign b_key  = brd_q[SW +: KEY_W];
	assign b_pay  = brd_q[SW-1:0];
	assign s_key  = srd_q[SDW-1 -: KEY_W];
	assign s_pay  = srd_q[SW-1:0];

	assign req_ready  = (state_q == ST_IDLE);
	assign hash_start = req_valid && req_ready;
	assign rsp_valid  = (state_q == ST_RESP);
	assign rsp.status  = res_status_q;
	assign rsp.payload = DATA_W'(res_pay_q);

	chte_bucket_mod #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.key   (req.key),
		.done  (hash_done),
		.bucket(hash_bkt)
	);

	// one key comparator serves the primary entry and every chain cell
	assign cmp_a  = (state_q == ST_EVAL) ? b_key : s_key;
	assign key_eq = (cmp_a == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			free_head_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (fh_we) begin
				free_head_q <= fh_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hash_start) begin
			func_q <= func_t'(req.func);
			key_q  <= req.key;
			pay_q  <= req.payload[SW-1:0];
		end
		if (state_q == ST_HASH) begin
			bkt_q <= hash_bkt;
		end
		if (walk_load) begin
			cur_q   <= b_head;
			prev_q  <= LINK_NULL;
			steps_q <= '0;
		end else if (walk_adv) begin
			cur_q   <= nrd_q;
			prev_q  <= cur_q;
			steps_q <= steps_q + LW'(1);
		end
		if (res_set) begin
			res_status_q <= res_status_d;
			res_pay_q    <= res_pay_d;
		end
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bucket_mem[bm_wa] <= bm_wd;
		end
		if (bm_re) begin
			brd_q <= bucket_mem[bm_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (sd_we) begin
			spill_mem[sd_wa] <= sd_wd;
		end
		if (sp_re) begin
			srd_q <= spill_mem[sp_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		if (sp_re) begin
			nrd_q <= next_mem[sp_ra];
		end
	end

	always_comb begin
		state_d      = state_q;
		bm_we        = 1'b0;
		bm_wa        = bkt_q;
		bm_wd        = {1'b1, LINK_NULL, key_q, pay_q};
		bm_re        = 1'b0;
		bm_ra        = hash_bkt;
		sd_we        = 1'b0;
		sd_wa        = free_head_q[SIW-1:0];
		sd_wd        = {key_q, pay_q};
		sp_re        = 1'b0;
		sp_ra        = b_head[SIW-1:0];
		nx_we        = 1'b0;
		nx_wa        = cur_q[SIW-1:0];
		nx_wd        = free_head_q;
		fh_we        = 1'b0;
		fh_d         = cur_q;
		walk_load    = 1'b0;
		walk_adv     = 1'b0;
		res_set      = 1'b0;
		res_status_d = STAT_OK;
		res_pay_d    = '0;

		unique case (state_q)
			ST_CLEAR: begin
				// free every bucket and chain the pool in order
				bm_we = (32'(clr_q) < TABLE_SIZE);
				bm_wa = clr_q[BW-1:0];
				bm_wd = {1'b0, LINK_NULL, {KEY_W{1'b0}}, {SW{1'b0}}};
				nx_we = (32'(clr_q) < SPILL_SIZE);
				nx_wa = clr_q[SIW-1:0];
				nx_wd = LW'(32'(clr_q) + 1);
				if (32'(clr_q) == CLR_N - 1) begin
					state_d = ST_IDLE;
				end
			end

			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_HASH;
				end
			end

			ST_HASH: begin
				if (hash_done) begin
					bm_re   = 1'b1;
					state_d = ST_EVAL;
				end
			end

			ST_EVAL: begin
				res_set      = 1'b1;
				res_status_d = STAT_MISS;
				state_d      = ST_RESP;
				case (func_q) inside
					FN_ADD: begin
						if (!b_used) begin
							bm_we        = 1'b1;
							res_status_d = STAT_OK;
						end else if (!link_ok(free_head_q)) begin
							res_status_d = STAT_FULL;
						end else begin
							sp_re   = 1'b1;
							sp_ra   = free_head_q[SIW-1:0];
							res_set = 1'b0;
							state_d = ST_ADD_WR;
						end
					end
					FN_SEARCH, FN_REMOVE: begin
						if (b_used && key_eq) begin
							if (func_q == FN_SEARCH) begin
								res_status_d = STAT_OK;
								res_pay_d    = b_pay;
							end else if (link_ok(b_head)) begin
								sp_re   = 1'b1;
								res_set = 1'b0;
								state_d = ST_PROMOTE;
							end else begin
								bm_we        = 1'b1;
								bm_wd        = {1'b0, LINK_NULL, b_key, b_pay};
								res_status_d = STAT_OK;
							end
						end else if (b_used && link_ok(b_head)) begin
							sp_re     = 1'b1;
							walk_load = 1'b1;
							res_set   = 1'b0;
							state_d   = ST_WALK;
						end
					end
					default: begin
					end
				endcase
			end

			ST_ADD_WR: begin
				// pop the free cell and push it on the bucket's chain
				fh_we        = 1'b1;
				fh_d         = nrd_q;
				nx_we        = 1'b1;
				nx_wa        = free_head_q[SIW-1:0];
				nx_wd        = b_head;
				sd_we        = 1'b1;
				bm_we        = 1'b1;
				bm_wd        = {1'b1, free_head_q, b_key, b_pay};
				res_set      = 1'b1;
				res_status_d = STAT_OK;
				state_d      = ST_RESP;
			end

			ST_PROMOTE: begin
				// move the first chain cell into the primary entry, free the cell
				bm_we        = 1'b1;
				bm_wd        = {1'b1, nrd_q, s_key, s_pay};
				nx_we        = 1'b1;
				nx_wa        = b_head[SIW-1:0];
				fh_we        = 1'b1;
				fh_d         = b_head;
				res_set      = 1'b1;
				res_status_d = STAT_OK;
				state_d      = ST_RESP;
			end

			ST_WALK: begin
				if (key_eq) begin
					if (func_q == FN_SEARCH) begin
						res_set      = 1'b1;
						res_status_d = STAT_OK;
						res_pay_d    = s_pay;
						state_d      = ST_RESP;
					end else begin
						// unlink here, release in the next cycle
						if (link_ok(prev_q)) begin
							nx_we = 1'b1;
							nx_wa = prev_q[SIW-1:0];
							nx_wd = nrd_q;
						end else begin
							bm_we = 1'b1;
							bm_wd = {1'b1, nrd_q, b_key, b_pay};
						end
						state_d = ST_RELEASE;
					end
				end else if (link_ok(nrd_q) && (32'(steps_q) + 1 < SPILL_SIZE)) begin
					sp_re    = 1'b1;
					sp_ra    = nrd_q[SIW-1:0];
					walk_adv = 1'b1;
				end else begin
					res_set      = 1'b1;
					res_status_d = STAT_MISS;
					state_d      = ST_RESP;
				end
			end

			ST_RELEASE: begin
				nx_we        = 1'b1;
				fh_we        = 1'b1;
				res_set      = 1'b1;
				res_status_d = STAT_OK;
				state_d      = ST_RESP;
			end

			ST_RESP: begin
				if (rsp_ready) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	a_free_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= LINK_NULL)
		else $error("free list head out of range");

	a_walk_cell_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (link_ok(cur_q) && (32'(steps_q) < SPILL_SIZE)))
		else $error("chain walk on a null cell or past the pool size");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while one is in progress");

	a_one_response: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready) |=> !rsp_valid)
		else $error("response handed over twice");

endmodule

`default_nettype wire

@@ design/chained_hash_table_engine_core.sv @@
// Top level of the chained hash table engine: stream ports and result register.
//
// Requests enter on the s_* channel: s_tuser carries the operation (add, search,
// remove) and s_tdata the key and the payload. One result per request leaves
// on the m_* channel: m_tuser carries the status, m_tdata the found payload.
// One request is in work at a time; s_tready is high only while the sequencer
// waits for a request.
// Each request runs through the hash, evaluate and result steps of the sequencer.
// An add onto a chain adds a chain write step, and a remove of a primary entry
// that has a chain adds a promote step. A search or remove in the chain adds a
// walk step per chain cell read, and a chain remove adds a release step. The walk
// is bounded to SPILL_SIZE chain cells. When TABLE_SIZE is not a power of two
// the hash step reduces the key a byte at a time.
// After reset a clearing pass over max(TABLE_SIZE, SPILL_SIZE) addresses frees all
// buckets and links the pool; s_tready stays low meanwhile.
// The result sits in an output register; a stalled receiver holds it there,
// and the sequencer stops in its result step until the register drains.
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_table_engine_core
	import chte_pkg::*;
#(
	parameter int TABLE_SIZE    = 256,
	parameter int SPILL_SIZE    = 64,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,  // key[63:0], entry_payload[95:64]
	input  wire logic [1:0]  s_tuser,  // func[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // found_payload[31:0]
	output logic [1:0]       m_tuser   // status[1:0]
);

	chte_req_t req;
	chte_rsp_t rsp;
	logic      rsp_valid;
	logic      out_free;

	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_data_q;
	status_t           m_status_q;

	assign req.func    = s_tuser;
	assign req.key     = s_tdata[KEY_W-1:0];
	assign req.payload = s_tdata[KEY_W +: DATA_W];

	assign out_free = !m_tvalid_q || m_tready;

	chte_table_ctrl #(
		.TABLE_SIZE   (TABLE_SIZE),
		.SPILL_SIZE   (SPILL_SIZE),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(out_free)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (rsp_valid && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// load the result only when the register is empty or draining
	always_ff @(posedge clk) begin
		if (rsp_valid && out_free) begin
			m_data_q   <= rsp.payload;
			m_status_q <= rsp.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_status_q;

endmodule

`default_nettype wire

@@ bench/chte_checker.sv @@
// Checker for the chained hash table engine: tracks the table and compares every result.
`timescale 1ns / 1ps

module chte_checker
	import chte_pkg::*;
#(
	parameter int TABLE_SIZE = 256,
	parameter int SPILL_SIZE = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [95:0] s_tdata,   // key[63:0], entry_payload[95:64]
	input  wire logic [1:0]  s_tuser,   // func[1:0]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,   // found_payload[31:0]
	input  wire logic [1:0]  m_tuser,   // status[1:0]
	output int               fail_count,
	output int               pending
);

	localparam int LINK_W = $clog2(SPILL_SIZE + 1);
	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(SPILL_SIZE);

	logic              occupied   [TABLE_SIZE];
	logic [LINK_W-1:0] chain_head [TABLE_SIZE];
	logic [KEY_W-1:0]  prim_key   [TABLE_SIZE];
	logic [DATA_W-1:0] prim_data  [TABLE_SIZE];
	logic [KEY_W-1:0]  cell_key   [SPILL_SIZE];
	logic [DATA_W-1:0] cell_data  [SPILL_SIZE];
	logic [LINK_W-1:0] cell_next  [SPILL_SIZE];
	logic [LINK_W-1:0] free_list;

	chte_rsp_t expected_results[$];
	chte_rsp_t want;

	task automatic clear_table();
		for (int i = 0; i < TABLE_SIZE; i++) begin
			occupied[i]   = 1'b0;
			chain_head[i] = LINK_NULL;
			prim_key[i]   = '0;
			prim_data[i]  = '0;
		end
		// chain the whole pool in order
		for (int i = 0; i < SPILL_SIZE; i++) begin
			cell_key[i]  = '0;
			cell_data[i] = '0;
			cell_next[i] = (i + 1 < SPILL_SIZE) ? LINK_W'(i + 1) : LINK_NULL;
		end
		free_list = '0;
	endtask

	// Apply one request to the tracked table and return the result it must produce.
	function automatic chte_rsp_t apply_request(input logic [1:0] fn, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] d);
		int unsigned b;
		int steps;
		logic [LINK_W-1:0] cur;
		logic [LINK_W-1:0] prev;
		chte_rsp_t r;
		r.status  = STAT_MISS;
		r.payload = '0;
		b = int'(k % 64'(TABLE_SIZE));
		case (fn)
			FN_ADD: begin
				if (!occupied[b]) begin
					occupied[b]   = 1'b1;
					chain_head[b] = LINK_NULL;
					prim_key[b]   = k;
					prim_data[b]  = d;
					r.status      = STAT_OK;
				end else if (free_list >= SPILL_SIZE) begin
					r.status = STAT_FULL;
				end else begin
					// pop a free cell and push it onto the bucket's chain
					cur            = free_list;
					free_list      = cell_next[cur];
					cell_next[cur] = chain_head[b];
					chain_head[b]  = cur;
					cell_key[cur]  = k;
					cell_data[cur] = d;
					r.status       = STAT_OK;
				end
			end
			FN_SEARCH, FN_REMOVE: begin
				if (occupied[b] && prim_key[b] == k) begin
					r.status = STAT_OK;
					if (fn == FN_SEARCH) begin
						r.payload = prim_data[b];
					end else begin
						cur = chain_head[b];
						if (cur < SPILL_SIZE) begin
							// promote the first chain cell into the primary entry
							prim_key[b]    = cell_key[cur];
							prim_data[b]   = cell_data[cur];
							chain_head[b]  = cell_next[cur];
							cell_next[cur] = free_list;
							free_list      = cur;
						end else begin
							occupied[b]   = 1'b0;
							chain_head[b] = LINK_NULL;
						end
					end
				end else if (occupied[b]) begin
					prev  = LINK_NULL;
					cur   = chain_head[b];
					steps = 0;
					while (cur < SPILL_SIZE && steps < SPILL_SIZE && cell_key[cur] != k) begin
						prev = cur;
						cur  = cell_next[cur];
						steps++;
					end
					if (cur < SPILL_SIZE && steps < SPILL_SIZE) begin
						r.status = STAT_OK;
						if (fn == FN_SEARCH) begin
							r.payload = cell_data[cur];
						end else begin
							if (prev < SPILL_SIZE)
								cell_next[prev] = cell_next[cur];
							else
								chain_head[b] = cell_next[cur];
							cell_next[cur] = free_list;
							free_list      = cur;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic log_mismatch(input string msg);
		if (fail_count < 10)
			$display("%0t: mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_table();
			expected_results.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// check the outgoing result before logging a new request
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					log_mismatch($sformatf("result with nothing pending: status %0d payload %h",
						m_tuser, m_tdata));
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.status)
						log_mismatch($sformatf("status expected %0d got %0d",
							want.status, m_tuser));
					if (m_tdata !== want.payload)
						log_mismatch($sformatf("found_payload expected %h got %h",
							want.payload, m_tdata));
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_request(s_tuser, s_tdata[63:0], s_tdata[95:64]));
			pending <= expected_results.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
// Top of the hash table engine bench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top
	import chte_pkg::*;
();

	localparam logic [1:0]       FN_UNUSED       = 2'd3;
	localparam logic [KEY_W-1:0] KEY_TOP         = '1;
	localparam logic [31:0]      DATA_TOP        = '1;
	localparam int               CYCLE_LIMIT     = 500000;
	localparam int               ITEMS_PER_PHASE = 175;
	localparam int               SQUEEZE_CYCLES  = 300;
	localparam int               DRAIN_CYCLES    = 150;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	int   fail_count;
	int   pending;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_off;
	logic squeeze_go;

	logic [7:0]       hot_bucket [4] = '{8'h00, 8'h5a, 8'ha5, 8'hff};
	logic [KEY_W-1:0] live_keys[$];

	chained_hash_table_engine_core #(
		.TABLE_SIZE   (256),
		.SPILL_SIZE   (64),
		.PAYLOAD_WIDTH(32)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	chte_checker #(
		.TABLE_SIZE(256),
		.SPILL_SIZE(64)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// hold the result channel for a long stretch so requests back up
	initial begin
		hold_off = 1'b0;
		wait (squeeze_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (SQUEEZE_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Most keys land in a few hot buckets to build long chains and drain the pool.
	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		k = {$urandom, $urandom};
		if ($urandom_range(99) < 80)
			k[7:0] = hot_bucket[$urandom_range(3)];
		return k;
	endfunction

	function automatic logic [KEY_W-1:0] known_or_fresh_key();
		if (live_keys.size() != 0 && $urandom_range(9) < 7)
			return live_keys[$urandom_range(live_keys.size() - 1)];
		return fresh_key();
	endfunction

	// Offer one request and return at the edge where it is taken; valid stays high.
	task automatic send_request(input logic [1:0] fn, input logic [KEY_W-1:0] k,
			input logic [31:0] d);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {d, k};
		do @(posedge clk); while (!s_tready);
	endtask

	initial begin
		int add_pct;
		int rm_pct;
		int roll;
		int pick;
		logic [KEY_W-1:0] k;

		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		squeeze_go     = 1'b0;
		send_idle_pct  = 31;
		recv_stall_pct = 31;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, collisions, duplicates, promotion, misses
		send_request(FN_ADD, 64'd0, 32'd0);
		send_request(FN_ADD, KEY_TOP, DATA_TOP);
		send_request(FN_SEARCH, 64'd0, DATA_TOP);
		send_request(FN_SEARCH, KEY_TOP, 32'd0);
		send_request(FN_ADD, 64'd256, 32'h1111_0100);
		send_request(FN_ADD, 64'd0, 32'hdead_0001);
		send_request(FN_SEARCH, 64'd0, 32'd0);
		send_request(FN_SEARCH, 64'd256, 32'd0);
		send_request(FN_SEARCH, 64'd512, 32'd0);
		send_request(FN_SEARCH, 64'd7, 32'd0);
		send_request(FN_UNUSED, 64'd0, 32'd0);
		send_request(FN_REMOVE, 64'd512, 32'd0);
		send_request(FN_REMOVE, 64'd7, 32'd0);
		send_request(FN_REMOVE, 64'd0, 32'd0);
		send_request(FN_SEARCH, 64'd0, 32'd0);
		send_request(FN_REMOVE, 64'd256, 32'd0);
		send_request(FN_REMOVE, 64'd0, 32'd0);
		send_request(FN_SEARCH, 64'd0, 32'd0);
		send_request(FN_REMOVE, 64'd0, 32'd0);
		send_request(FN_REMOVE, KEY_TOP, 32'd0);
		send_request(FN_SEARCH, KEY_TOP, 32'd0);
		send_request(FN_UNUSED, KEY_TOP, DATA_TOP);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 0;
					add_pct = 60;
					rm_pct  = 15;
				end
				1: begin
					send_idle_pct  <= 64;
					recv_stall_pct <= 0;
					add_pct = 45;
					rm_pct  = 30;
				end
				2: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 64;
					add_pct = 25;
					rm_pct  = 50;
				end
				default: begin
					send_idle_pct  <= 31;
					recv_stall_pct <= 31;
					add_pct = 40;
					rm_pct  = 35;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 0 && n == 40)
					squeeze_go <= 1'b1;
				roll = $urandom_range(99);
				if (roll < add_pct) begin
					// reuse a known key now and then to store duplicates
					if (live_keys.size() != 0 && $urandom_range(3) == 0)
						k = live_keys[$urandom_range(live_keys.size() - 1)];
					else
						k = fresh_key();
					live_keys.push_back(k);
					send_request(FN_ADD, k, $urandom);
				end else if (roll < add_pct + rm_pct) begin
					if (live_keys.size() != 0 && $urandom_range(9) < 8) begin
						pick = $urandom_range(live_keys.size() - 1);
						k = live_keys[pick];
						live_keys.delete(pick);
					end else begin
						k = fresh_key();
					end
					send_request(FN_REMOVE, k, $urandom);
				end else if (roll < 98) begin
					send_request(FN_SEARCH, known_or_fresh_key(), $urandom);
				end else begin
					send_request(FN_UNUSED, fresh_key(), $urandom);
				end
			end
		end
		s_tvalid <= 1'b0;

		// the checker's pending count is registered and lags the final accept
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
